// File: rtl/fri_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fri_pkg;

   // default degree format and queue size
   localparam int FRACTION_BITS_DEFAULT = 8;
   localparam int QUEUE_DEPTH_DEFAULT   = 2;

   localparam int ERR_W = 13;
   localparam int CHG_W = 12;
   localparam int OUT_W = 9;
   localparam int OUT_MAX = 511;

   // five error sets then five change sets
   localparam int NUM_SETS = 10;
   localparam int SETS_PER_INPUT = 5;
   localparam int DIST_W = 9;

   // reciprocal shift: exact floor for slope widths up to 512
   localparam int RECIP_SHIFT = 18;

   // error breakpoints
   localparam int ERR_GRN_B = -1000;
   localparam int ERR_GRN_C = -650;
   localparam int ERR_PQN_A = -1000;
   localparam int ERR_PQN_B = -500;
   localparam int ERR_PQN_C = -100;
   localparam int ERR_ZER_A = -250;
   localparam int ERR_ZER_B = 0;
   localparam int ERR_ZER_C = 250;
   localparam int ERR_PQP_A = 100;
   localparam int ERR_PQP_B = 500;
   localparam int ERR_PQP_C = 1000;
   localparam int ERR_GRP_A = 650;
   localparam int ERR_GRP_B = 1000;

   // change breakpoints
   localparam int CHG_GRN_B = -300;
   localparam int CHG_GRN_C = -180;
   localparam int CHG_PQN_A = -300;
   localparam int CHG_PQN_B = -180;
   localparam int CHG_PQN_C = -60;
   localparam int CHG_ZER_A = -100;
   localparam int CHG_ZER_B = 0;
   localparam int CHG_ZER_C = 100;
   localparam int CHG_PQP_A = 60;
   localparam int CHG_PQP_B = 180;
   localparam int CHG_PQP_C = 300;
   localparam int CHG_GRP_A = 180;
   localparam int CHG_GRP_B = 300;

   // slope widths per set (a shoulder repeats its one slope on both sides)
   localparam int SET_RISE_W [NUM_SETS] = '{
      ERR_GRN_C - ERR_GRN_B, ERR_PQN_B - ERR_PQN_A, ERR_ZER_B - ERR_ZER_A,
      ERR_PQP_B - ERR_PQP_A, ERR_GRP_B - ERR_GRP_A,
      CHG_GRN_C - CHG_GRN_B, CHG_PQN_B - CHG_PQN_A, CHG_ZER_B - CHG_ZER_A,
      CHG_PQP_B - CHG_PQP_A, CHG_GRP_B - CHG_GRP_A};
   localparam int SET_FALL_W [NUM_SETS] = '{
      ERR_GRN_C - ERR_GRN_B, ERR_PQN_C - ERR_PQN_B, ERR_ZER_C - ERR_ZER_B,
      ERR_PQP_C - ERR_PQP_B, ERR_GRP_B - ERR_GRP_A,
      CHG_GRN_C - CHG_GRN_B, CHG_PQN_C - CHG_PQN_B, CHG_ZER_C - CHG_ZER_B,
      CHG_PQP_C - CHG_PQP_B, CHG_GRP_B - CHG_GRP_A};

   typedef enum logic [1:0] {
      MF_ZERO,
      MF_ONE,
      MF_RISE,
      MF_FALL
   } mf_region_type;

   typedef struct packed {
      mf_region_type     region;
      logic [DIST_W-1:0] delta;
   } mf_cls_type;

   typedef enum logic [2:0] {
      CLS_SR,
      CLS_MR,
      CLS_SMR,
      CLS_CEN,
      CLS_SML,
      CLS_ML,
      CLS_SL
   } out_class_type;

   localparam int NUM_CLASSES = 7;

   // class of rule [error set][change set]
   localparam out_class_type RULE_CLASS [SETS_PER_INPUT][SETS_PER_INPUT] = '{
      '{CLS_SR,  CLS_SR,  CLS_MR,  CLS_SMR, CLS_SMR},
      '{CLS_SR,  CLS_MR,  CLS_SMR, CLS_CEN, CLS_SMR},
      '{CLS_MR,  CLS_SMR, CLS_CEN, CLS_SML, CLS_ML },
      '{CLS_SML, CLS_CEN, CLS_SML, CLS_ML,  CLS_SL },
      '{CLS_SMR, CLS_SML, CLS_ML,  CLS_SL,  CLS_SL }};

   typedef struct packed {
      logic signed [ERR_W-1:0] error_value;
      logic signed [CHG_W-1:0] error_change;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] strong_right;
      logic [OUT_W-1:0] medium_right;
      logic [OUT_W-1:0] small_right;
      logic [OUT_W-1:0] centre_class;
      logic [OUT_W-1:0] small_left;
      logic [OUT_W-1:0] medium_left;
      logic [OUT_W-1:0] strong_left;
   } rsp_type;

   // triangle a, b, c
   function automatic mf_cls_type mf_tri(input int x, input int a, input int b,
                                         input int c);
      mf_cls_type r;
      int         dist_full;
      r.region = MF_ZERO;
      dist_full = 0;
      if (x <= a || x >= c) begin
         r.region = MF_ZERO;
      end else if (x == b) begin
         r.region = MF_ONE;
      end else if (x < b) begin
         r.region = MF_RISE;
         dist_full = x - a;
      end else begin
         r.region = MF_FALL;
         dist_full = c - x;
      end
      r.delta = dist_full[DIST_W-1:0];
      return r;
   endfunction

   // left shoulder: one up to b, zero from c
   function automatic mf_cls_type mf_low(input int x, input int b, input int c);
      mf_cls_type r;
      int         dist_full;
      r.region = MF_ZERO;
      dist_full = 0;
      if (x <= b) begin
         r.region = MF_ONE;
      end else if (x >= c) begin
         r.region = MF_ZERO;
      end else begin
         r.region = MF_FALL;
         dist_full = c - x;
      end
      r.delta = dist_full[DIST_W-1:0];
      return r;
   endfunction

   // right shoulder: zero up to a, one from b
   function automatic mf_cls_type mf_high(input int x, input int a, input int b);
      mf_cls_type r;
      int         dist_full;
      r.region = MF_ZERO;
      dist_full = 0;
      if (x <= a) begin
         r.region = MF_ZERO;
      end else if (x >= b) begin
         r.region = MF_ONE;
      end else begin
         r.region = MF_RISE;
         dist_full = x - a;
      end
      r.delta = dist_full[DIST_W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/fri_fuzzify.sv
`timescale 1ns / 1ps
`default_nettype none

module fri_fuzzify #(
   parameter int FRACTION_BITS = fri_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire fri_pkg::req_type      in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [fri_pkg::NUM_SETS-1:0][FRACTION_BITS:0] out_deg
);

   localparam int DW = FRACTION_BITS + 1;
   localparam int K  = fri_pkg::RECIP_SHIFT;
   localparam int MW = FRACTION_BITS + 12;
   localparam int PW = MW + fri_pkg::DIST_W;
   localparam logic [DW-1:0] DEG_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s1_adv, s2_adv;

   fri_pkg::mf_cls_type cls_in [fri_pkg::NUM_SETS];
   fri_pkg::mf_cls_type cls_ff [fri_pkg::NUM_SETS];
   logic [fri_pkg::NUM_SETS-1:0][DW-1:0] deg_in, deg_ff;

   // stall chain: stage 2 moves when empty or taken, stage 1 when stage 2 moves
   assign s2_adv   = !s2_valid_ff || out_ready;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;

   assign s1_valid_in = s1_adv ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;

   // classify each input against its five sets
   always_comb begin
      int ev;
      int cv;
      ev = int'(in_data.error_value);
      cv = int'(in_data.error_change);
      cls_in[0] = fri_pkg::mf_low(ev, fri_pkg::ERR_GRN_B, fri_pkg::ERR_GRN_C);
      cls_in[1] = fri_pkg::mf_tri(ev, fri_pkg::ERR_PQN_A, fri_pkg::ERR_PQN_B,
                                  fri_pkg::ERR_PQN_C);
      cls_in[2] = fri_pkg::mf_tri(ev, fri_pkg::ERR_ZER_A, fri_pkg::ERR_ZER_B,
                                  fri_pkg::ERR_ZER_C);
      cls_in[3] = fri_pkg::mf_tri(ev, fri_pkg::ERR_PQP_A, fri_pkg::ERR_PQP_B,
                                  fri_pkg::ERR_PQP_C);
      cls_in[4] = fri_pkg::mf_high(ev, fri_pkg::ERR_GRP_A, fri_pkg::ERR_GRP_B);
      cls_in[5] = fri_pkg::mf_low(cv, fri_pkg::CHG_GRN_B, fri_pkg::CHG_GRN_C);
      cls_in[6] = fri_pkg::mf_tri(cv, fri_pkg::CHG_PQN_A, fri_pkg::CHG_PQN_B,
                                  fri_pkg::CHG_PQN_C);
      cls_in[7] = fri_pkg::mf_tri(cv, fri_pkg::CHG_ZER_A, fri_pkg::CHG_ZER_B,
                                  fri_pkg::CHG_ZER_C);
      cls_in[8] = fri_pkg::mf_tri(cv, fri_pkg::CHG_PQP_A, fri_pkg::CHG_PQP_B,
                                  fri_pkg::CHG_PQP_C);
      cls_in[9] = fri_pkg::mf_high(cv, fri_pkg::CHG_GRP_A, fri_pkg::CHG_GRP_B);
   end

   // slope degree: floor(d * ONE / w) as d times a rounded-up reciprocal
   for (genvar g = 0; g < fri_pkg::NUM_SETS; g++) begin : g_slope
      localparam logic [63:0] RISE_M64 =
         ((64'd1 << (FRACTION_BITS + K)) + 64'(fri_pkg::SET_RISE_W[g]) - 64'd1)
         / 64'(fri_pkg::SET_RISE_W[g]);
      localparam logic [63:0] FALL_M64 =
         ((64'd1 << (FRACTION_BITS + K)) + 64'(fri_pkg::SET_FALL_W[g]) - 64'd1)
         / 64'(fri_pkg::SET_FALL_W[g]);

      logic [MW-1:0] m_sel;
      logic [PW-1:0] prod;

      always_comb begin
         m_sel = (cls_ff[g].region == fri_pkg::MF_RISE) ? RISE_M64[MW-1:0]
                                                         : FALL_M64[MW-1:0];
         prod  = {{MW{1'b0}}, cls_ff[g].delta} * {{fri_pkg::DIST_W{1'b0}}, m_sel};
         case (cls_ff[g].region)
            fri_pkg::MF_ZERO: deg_in[g] = '0;
            fri_pkg::MF_ONE:  deg_in[g] = DEG_ONE;
            fri_pkg::MF_RISE,
            fri_pkg::MF_FALL: deg_in[g] = prod[K +: DW];
            default:          deg_in[g] = '0;
         endcase
      end
   end

   // hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // advance payload stages
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         cls_ff <= cls_in;
      end
      if (s2_adv) begin
         deg_ff <= deg_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_deg   = deg_ff;

`ifndef NO_ASSERTIONS
   logic [fri_pkg::SETS_PER_INPUT-1:0] err_nz, chg_nz;
   always_comb begin
      for (int i = 0; i < fri_pkg::SETS_PER_INPUT; i++) begin
         err_nz[i] = (deg_ff[i] != '0);
         chg_nz[i] = (deg_ff[fri_pkg::SETS_PER_INPUT + i] != '0);
      end
   end

   // neighboring sets overlap in pairs only
   a_two_sets_active: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> ($countones(err_nz) <= 2 && $countones(chg_nz) <= 2))
      else $error("more than two membership degrees nonzero");
`endif

endmodule

`default_nettype wire

// File: rtl/fri_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fri_queue #(
   parameter int DEPTH = fri_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int WIDTH = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store item
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue occupancy beyond depth");

   a_hold_unpopped: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid)
      else $error("queue lost an item that was not popped");
`endif

endmodule

`default_nettype wire

// File: rtl/fri_rules.sv
`timescale 1ns / 1ps
`default_nettype none

module fri_rules #(
   parameter int FRACTION_BITS = fri_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [fri_pkg::NUM_SETS-1:0][FRACTION_BITS:0] in_deg,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output fri_pkg::rsp_type           out_data
);

   localparam int DW = FRACTION_BITS + 1;
   localparam int N  = fri_pkg::SETS_PER_INPUT;
   localparam int LIMIT = ((1 << FRACTION_BITS) < fri_pkg::OUT_MAX) ?
                          (1 << FRACTION_BITS) : fri_pkg::OUT_MAX;

   logic             out_valid_ff, out_valid_in;
   fri_pkg::rsp_type out_data_ff, out_data_in;
   logic [DW-1:0]    cls_max [fri_pkg::NUM_CLASSES];
   logic             pop;

   function automatic logic [fri_pkg::OUT_W-1:0] sat(input logic [DW-1:0] v);
      if (32'(v) > 32'(fri_pkg::OUT_MAX)) begin
         return fri_pkg::OUT_W'(fri_pkg::OUT_MAX);
      end
      return fri_pkg::OUT_W'(v);
   endfunction

   assign pop      = in_valid && (!out_valid_ff || out_ready);
   assign in_ready = !out_valid_ff || out_ready;

   // fire rules by min, merge into classes by max
   always_comb begin
      logic [DW-1:0] rule_str;
      rule_str = '0;
      for (int k = 0; k < fri_pkg::NUM_CLASSES; k++) begin
         cls_max[k] = '0;
      end
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            rule_str = (in_deg[i] < in_deg[N + j]) ? in_deg[i] : in_deg[N + j];
            for (int k = 0; k < fri_pkg::NUM_CLASSES; k++) begin
               if (fri_pkg::RULE_CLASS[i][j] == fri_pkg::out_class_type'(3'(k)) &&
                   rule_str > cls_max[k]) begin
                  cls_max[k] = rule_str;
               end
            end
         end
      end
   end

   always_comb begin
      out_data_in.strong_right = sat(cls_max[fri_pkg::CLS_SR]);
      out_data_in.medium_right = sat(cls_max[fri_pkg::CLS_MR]);
      out_data_in.small_right  = sat(cls_max[fri_pkg::CLS_SMR]);
      out_data_in.centre_class = sat(cls_max[fri_pkg::CLS_CEN]);
      out_data_in.small_left   = sat(cls_max[fri_pkg::CLS_SML]);
      out_data_in.medium_left  = sat(cls_max[fri_pkg::CLS_ML]);
      out_data_in.strong_left  = sat(cls_max[fri_pkg::CLS_SL]);
   end

   assign out_valid_in = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // hold result until taken
   always_ff @(posedge clock) begin
      if (pop) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

`ifndef NO_ASSERTIONS
   a_strength_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (32'(out_data_ff.strong_right) <= LIMIT &&
                        32'(out_data_ff.medium_right) <= LIMIT &&
                        32'(out_data_ff.small_right)  <= LIMIT &&
                        32'(out_data_ff.centre_class) <= LIMIT &&
                        32'(out_data_ff.small_left)   <= LIMIT &&
                        32'(out_data_ff.medium_left)  <= LIMIT &&
                        32'(out_data_ff.strong_left)  <= LIMIT))
      else $error("class strength above full degree");
`endif

endmodule

`default_nettype wire

// File: rtl/fuzzy_rule_inference_5x5.sv
// Channel  Ports                            Payload
// -------  -------------------------------  ----------------------------------
// request  req_valid, req_ready, req_data   error_value, error_change
// response rsp_valid, rsp_ready, rsp_data   seven class strengths, 9 bits each
//
// One item per cycle sustained while rsp_ready stays high; each item yields
// one response item. With no stalls an accepted request passes through the
// classify stage, the constant-reciprocal multiply stage, the queue write and
// the rule min/max output register, in that order, before rsp_valid rises.
// Synchronous reset clears all valid flags and queue pointers; no clearing pass.
// A stalled response fills the queue first; req_ready drops once it and the
// fuzzifier stages are full.
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_rule_inference_5x5 #(
   parameter int FRACTION_BITS = fri_pkg::FRACTION_BITS_DEFAULT,
   parameter int QUEUE_DEPTH   = fri_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire fri_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output fri_pkg::rsp_type      rsp_data
);

   localparam int DW = FRACTION_BITS + 1;
   localparam int QW = fri_pkg::NUM_SETS * DW;

   logic                                 fz_valid, fz_ready;
   logic [fri_pkg::NUM_SETS-1:0][DW-1:0] fz_deg;
   logic                                 q_valid, q_ready;
   logic [fri_pkg::NUM_SETS-1:0][DW-1:0] q_deg;

   // front: fuzzify
   fri_fuzzify #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_fuzzify (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_data  (req_data),
      .out_valid(fz_valid),
      .out_ready(fz_ready),
      .out_deg  (fz_deg)
   );

   // decouple front from back
   fri_queue #(
      .DEPTH(QUEUE_DEPTH),
      .WIDTH(QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fz_valid),
      .in_ready (fz_ready),
      .in_data  (fz_deg),
      .out_valid(q_valid),
      .out_ready(q_ready),
      .out_data (q_deg)
   );

   // back: rule evaluation
   fri_rules #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_rules (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_valid),
      .in_ready (q_ready),
      .in_deg   (q_deg),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_data (rsp_data)
   );

endmodule

`default_nettype wire
